>>> hw/rtl/carg_pkg.sv
// shared constants, table entry layouts and codes for the admission rate guard
// no dependencies
package carg_pkg;

   localparam int SRC_ENTRIES = 2048;
   localparam int NET_ENTRIES = 1024;
   localparam int BAN_ENTRIES = 512;

   localparam int SRC_AW = $clog2(SRC_ENTRIES);
   localparam int NET_AW = $clog2(NET_ENTRIES);
   localparam int BAN_AW = $clog2(BAN_ENTRIES);

   localparam int MAX_ENTRIES = (SRC_ENTRIES > NET_ENTRIES) ?
      ((SRC_ENTRIES > BAN_ENTRIES) ? SRC_ENTRIES : BAN_ENTRIES) :
      ((NET_ENTRIES > BAN_ENTRIES) ? NET_ENTRIES : BAN_ENTRIES);
   localparam int MAX_AW = $clog2(MAX_ENTRIES);
   localparam int IDX_W  = MAX_AW + 1;

   localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;

   localparam logic [15:0] WINDOW_RESET    = 16'd60;
   localparam logic [15:0] SRC_LIMIT_RESET = 16'd12;
   localparam logic [15:0] NET_LIMIT_RESET = 16'd60;
   localparam logic [15:0] BAN_SEC_RESET   = 16'd300;
   localparam logic [15:0] STORE_LIM_RESET = 16'd10000;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW    = 3'd0,
      REG_SRC_LIMIT = 3'd1,
      REG_NET_LIMIT = 3'd2,
      REG_BAN_SEC   = 3'd3,
      REG_STORE_LIM = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      V_OK       = 3'd0,
      V_BANNED   = 3'd1,
      V_PRESSURE = 3'd2,
      V_SRC      = 3'd3,
      V_NET      = 3'd4,
      V_STORE    = 3'd5
   } verdict_type;

   localparam logic CMD_STORE = 1'b1;

   typedef struct packed {
      logic        used;
      logic [31:0] key;
      logic [15:0] cnt;
      logic [31:0] start;
   } rate_entry_type;

   typedef struct packed {
      logic        used;
      logic [31:0] addr;
      logic [31:0] expiry;
   } ban_entry_type;

endpackage

>>> hw/rtl/carg_if.sv
// channel interfaces: request, response and register write
// depends on carg_pkg
interface carg_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] source_ip;
   logic [31:0] now_sec;
   logic        pressure;
   modport source (output valid, cmd, source_ip, now_sec, pressure, input ready);
   modport sink   (input valid, cmd, source_ip, now_sec, pressure, output ready);
endinterface

interface carg_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic [2:0] verdict;
   modport source (output valid, accepted, verdict, input ready);
   modport sink   (input valid, accepted, verdict, output ready);
endinterface

interface carg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [carg_pkg::CSR_IDX_W-1:0] index;
   logic [15:0]                    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/carg_ram.sv
// generic single write port ram with registered read
// no dependencies
module carg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

>>> hw/rtl/connection_admission_rate_guard.sv
// admission guard top level: ban sweep, per source and per subnet windows, store window
// depends on carg_pkg, carg_if, carg_ram
//
//  port      dir   word
//  req_bus   in    cmd, source_ip, now_sec, pressure
//  rsp_bus   out   accepted, verdict
//  csr_bus   in    index, data (always ready)
//
// store word: store state, then response handshake
// inbound word: ban sweep (up to every ban entry), source scan (up to every source entry),
//   subnet scan (up to every subnet entry); one table entry read per cycle through the
//   shared scan compare unit
// after reset a clearing pass over every table entry runs before the first word is taken
// one word at a time; a waiting response holds off the next request
module connection_admission_rate_guard (
   input  logic       clock,
   input  logic       reset,
   carg_req_if.sink   req_bus,
   carg_rsp_if.source rsp_bus,
   carg_csr_if.sink   csr_bus
);

   localparam int RW = $bits(carg_pkg::rate_entry_type);
   localparam int BW = $bits(carg_pkg::ban_entry_type);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_STORE, S_BAN, S_SRC, S_NET, S_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [carg_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        pend_ff, pend_in;
   logic [carg_pkg::MAX_AW-1:0] pidx_ff, pidx_in;
   logic                        have_free_ff, have_free_in;
   logic [carg_pkg::MAX_AW-1:0] free_ff, free_in;
   logic                        have_old_ff, have_old_in;
   logic [carg_pkg::MAX_AW-1:0] old_ff, old_in;
   logic [31:0]                 best_ff, best_in;
   logic [carg_pkg::BAN_AW-1:0] ban_slot_ff, ban_slot_in;

   logic        cmd_ff, cmd_in;
   logic [31:0] ip_ff, ip_in;
   logic [31:0] now_ff, now_in;
   logic        press_ff, press_in;

   logic [15:0] win_ff, src_lim_ff, net_lim_ff, ban_sec_ff, store_lim_ff;
   logic [15:0] store_cnt_ff, store_cnt_in;
   logic [31:0] store_start_ff, store_start_in;

   logic       rsp_vld_ff, rsp_vld_in;
   logic       rsp_acc_ff, rsp_acc_in;
   logic [2:0] rsp_verdict_ff, rsp_verdict_in;

   logic [RW-1:0] src_rdata, net_rdata;
   logic [BW-1:0] ban_rdata;
   logic          src_we, net_we, ban_we;
   logic [RW-1:0] src_wdata, net_wdata;
   logic [BW-1:0] ban_wdata;
   logic [carg_pkg::SRC_AW-1:0] src_waddr;
   logic [carg_pkg::NET_AW-1:0] net_waddr;
   logic [carg_pkg::BAN_AW-1:0] ban_waddr;

   carg_pkg::rate_entry_type rate_rd, rate_wd;
   carg_pkg::ban_entry_type  ban_rd, ban_wd;
   logic                     rate_we;
   logic [carg_pkg::MAX_AW-1:0] rate_waddr;
   logic [31:0]              rate_key, age, left, ban_diff;
   logic [15:0]              rate_lim;
   logic [carg_pkg::IDX_W-1:0] depth;
   logic                     scan_end, rate_ok, rate_fail;
   logic [carg_pkg::MAX_AW-1:0] new_slot;
   logic [2:0]               fin_v;
   logic                     fin;

   carg_ram #(.WIDTH(RW), .DEPTH(carg_pkg::SRC_ENTRIES)) u_src_ram (
      .clock (clock), .we (src_we), .waddr (src_waddr), .wdata (src_wdata),
      .raddr (idx_ff[carg_pkg::SRC_AW-1:0]), .rdata (src_rdata)
   );

   carg_ram #(.WIDTH(RW), .DEPTH(carg_pkg::NET_ENTRIES)) u_net_ram (
      .clock (clock), .we (net_we), .waddr (net_waddr), .wdata (net_wdata),
      .raddr (idx_ff[carg_pkg::NET_AW-1:0]), .rdata (net_rdata)
   );

   carg_ram #(.WIDTH(BW), .DEPTH(carg_pkg::BAN_ENTRIES)) u_ban_ram (
      .clock (clock), .we (ban_we), .waddr (ban_waddr), .wdata (ban_wdata),
      .raddr (idx_ff[carg_pkg::BAN_AW-1:0]), .rdata (ban_rdata)
   );

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign rsp_bus.valid    = rsp_vld_ff;
   assign rsp_bus.accepted = rsp_acc_ff;
   assign rsp_bus.verdict  = rsp_verdict_ff;
   assign csr_bus.ready    = 1'b1;

   // shared scan unit
   always_comb begin
      rate_rd  = (state_ff == S_SRC) ? carg_pkg::rate_entry_type'(src_rdata)
                                      : carg_pkg::rate_entry_type'(net_rdata);
      ban_rd   = carg_pkg::ban_entry_type'(ban_rdata);
      rate_key = (state_ff == S_SRC) ? ip_ff : (ip_ff & carg_pkg::SUBNET_MASK);
      rate_lim = (state_ff == S_SRC) ? src_lim_ff : net_lim_ff;
      age      = now_ff - rate_rd.start;
      left     = ban_rd.expiry - now_ff;
      ban_diff = now_ff - ban_rd.expiry;
      new_slot = have_free_ff ? free_ff : old_ff;
      case (state_ff)
         S_BAN:   depth = carg_pkg::IDX_W'(carg_pkg::BAN_ENTRIES);
         S_SRC:   depth = carg_pkg::IDX_W'(carg_pkg::SRC_ENTRIES);
         S_NET:   depth = carg_pkg::IDX_W'(carg_pkg::NET_ENTRIES);
         default: depth = carg_pkg::IDX_W'(carg_pkg::MAX_ENTRIES);
      endcase
      scan_end = !pend_ff && (idx_ff == depth);
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pidx_in        = pidx_ff;
      have_free_in   = have_free_ff;
      free_in        = free_ff;
      have_old_in    = have_old_ff;
      old_in         = old_ff;
      best_in        = best_ff;
      ban_slot_in    = ban_slot_ff;
      cmd_in         = cmd_ff;
      ip_in          = ip_ff;
      now_in         = now_ff;
      press_in       = press_ff;
      store_cnt_in   = store_cnt_ff;
      store_start_in = store_start_ff;
      rsp_vld_in     = rsp_vld_ff;
      rsp_acc_in     = rsp_acc_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rate_we        = 1'b0;
      rate_waddr     = pidx_ff;
      rate_wd        = '0;
      ban_we         = 1'b0;
      ban_waddr      = pidx_ff[carg_pkg::BAN_AW-1:0];
      ban_wd         = '0;
      src_we         = 1'b0;
      net_we         = 1'b0;
      src_waddr      = pidx_ff[carg_pkg::SRC_AW-1:0];
      net_waddr      = pidx_ff[carg_pkg::NET_AW-1:0];
      rate_ok        = 1'b0;
      rate_fail      = 1'b0;
      fin            = 1'b0;
      fin_v          = carg_pkg::V_OK;

      if (state_ff == S_BAN || state_ff == S_SRC || state_ff == S_NET) begin
         if (idx_ff != depth) begin
            idx_in  = idx_ff + 1'b1;
            pend_in = 1'b1;
            pidx_in = idx_ff[carg_pkg::MAX_AW-1:0];
         end else begin
            pend_in = 1'b0;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            idx_in    = idx_ff + 1'b1;
            src_waddr = idx_ff[carg_pkg::SRC_AW-1:0];
            net_waddr = idx_ff[carg_pkg::NET_AW-1:0];
            ban_waddr = idx_ff[carg_pkg::BAN_AW-1:0];
            src_we    = (idx_ff < carg_pkg::IDX_W'(carg_pkg::SRC_ENTRIES));
            net_we    = (idx_ff < carg_pkg::IDX_W'(carg_pkg::NET_ENTRIES));
            ban_we    = (idx_ff < carg_pkg::IDX_W'(carg_pkg::BAN_ENTRIES));
            if (idx_ff == carg_pkg::IDX_W'(carg_pkg::MAX_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in       = req_bus.cmd;
               ip_in        = req_bus.source_ip;
               now_in       = req_bus.now_sec;
               press_in     = req_bus.pressure;
               idx_in       = '0;
               pend_in      = 1'b0;
               have_free_in = 1'b0;
               have_old_in  = 1'b0;
               state_in     = (req_bus.cmd == carg_pkg::CMD_STORE) ? S_STORE : S_BAN;
            end
         end
         S_STORE: begin
            fin = 1'b1;
            if (press_ff) begin
               fin_v = carg_pkg::V_PRESSURE;
            end else if (store_start_ff == 32'd0 ||
                         (now_ff - store_start_ff) > {16'd0, win_ff}) begin
               store_start_in = now_ff;
               store_cnt_in   = 16'd1;
            end else if (store_cnt_ff >= store_lim_ff) begin
               fin_v = carg_pkg::V_STORE;
            end else begin
               store_cnt_in = store_cnt_ff + 16'd1;
            end
         end
         S_BAN: begin
            if (pend_ff) begin
               if (ban_rd.used && !ban_diff[31]) begin
                  ban_we = 1'b1;
                  ban_wd = ban_rd;
                  ban_wd.used = 1'b0;
                  if (!have_free_ff) begin
                     have_free_in = 1'b1;
                     free_in      = pidx_ff;
                  end
               end else if (ban_rd.used && ban_rd.addr == ip_ff) begin
                  fin   = 1'b1;
                  fin_v = carg_pkg::V_BANNED;
               end else if (ban_rd.used) begin
                  if (!have_old_ff || left < best_ff) begin
                     have_old_in = 1'b1;
                     old_in      = pidx_ff;
                     best_in     = left;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = pidx_ff;
               end
            end else if (scan_end) begin
               ban_slot_in = new_slot[carg_pkg::BAN_AW-1:0];
               if (press_ff) begin
                  fin   = 1'b1;
                  fin_v = carg_pkg::V_PRESSURE;
               end else begin
                  state_in     = S_SRC;
                  idx_in       = '0;
                  pend_in      = 1'b0;
                  have_free_in = 1'b0;
                  have_old_in  = 1'b0;
               end
            end
         end
         S_SRC, S_NET: begin
            if (pend_ff) begin
               if (!rate_rd.used) begin
                  if (!have_free_ff) begin
                     have_free_in = 1'b1;
                     free_in      = pidx_ff;
                  end
               end else begin
                  if (!have_old_ff || age > best_ff) begin
                     have_old_in = 1'b1;
                     old_in      = pidx_ff;
                     best_in     = age;
                  end
                  if (rate_rd.key == rate_key) begin
                     if (age > {16'd0, win_ff}) begin
                        rate_we  = 1'b1;
                        rate_wd  = '{used: 1'b1, key: rate_key, cnt: 16'd1, start: now_ff};
                        rate_ok  = 1'b1;
                     end else if (rate_rd.cnt >= rate_lim) begin
                        rate_fail = 1'b1;
                     end else begin
                        rate_we     = 1'b1;
                        rate_wd     = rate_rd;
                        rate_wd.cnt = rate_rd.cnt + 16'd1;
                        rate_ok     = 1'b1;
                     end
                  end
               end
            end else if (scan_end) begin
               rate_we    = 1'b1;
               rate_waddr = new_slot;
               rate_wd    = '{used: 1'b1, key: rate_key, cnt: 16'd1, start: now_ff};
               rate_ok    = 1'b1;
            end
            if (state_ff == S_SRC) begin
               src_we    = rate_we;
               src_waddr = rate_waddr[carg_pkg::SRC_AW-1:0];
               if (rate_ok) begin
                  state_in     = S_NET;
                  idx_in       = '0;
                  pend_in      = 1'b0;
                  have_free_in = 1'b0;
                  have_old_in  = 1'b0;
               end else if (rate_fail) begin
                  ban_we    = 1'b1;
                  ban_waddr = ban_slot_ff;
                  ban_wd    = '{used: 1'b1, addr: ip_ff, expiry: now_ff + {16'd0, ban_sec_ff}};
                  fin       = 1'b1;
                  fin_v     = carg_pkg::V_SRC;
               end
            end else begin
               net_we    = rate_we;
               net_waddr = rate_waddr[carg_pkg::NET_AW-1:0];
               if (rate_ok) begin
                  fin = 1'b1;
               end else if (rate_fail) begin
                  fin   = 1'b1;
                  fin_v = carg_pkg::V_NET;
               end
            end
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               rsp_vld_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         state_in       = S_RESP;
         rsp_vld_in     = 1'b1;
         rsp_acc_in     = (fin_v == carg_pkg::V_OK);
         rsp_verdict_in = fin_v;
      end
   end

   assign src_wdata = (state_ff == S_CLEAR) ? '0 : RW'(rate_wd);
   assign net_wdata = (state_ff == S_CLEAR) ? '0 : RW'(rate_wd);
   assign ban_wdata = (state_ff == S_CLEAR) ? '0 : BW'(ban_wd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         idx_ff         <= '0;
         pend_ff        <= 1'b0;
         have_free_ff   <= 1'b0;
         have_old_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         store_cnt_ff   <= '0;
         store_start_ff <= '0;
         win_ff         <= carg_pkg::WINDOW_RESET;
         src_lim_ff     <= carg_pkg::SRC_LIMIT_RESET;
         net_lim_ff     <= carg_pkg::NET_LIMIT_RESET;
         ban_sec_ff     <= carg_pkg::BAN_SEC_RESET;
         store_lim_ff   <= carg_pkg::STORE_LIM_RESET;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         pend_ff        <= pend_in;
         have_free_ff   <= have_free_in;
         have_old_ff    <= have_old_in;
         rsp_vld_ff     <= rsp_vld_in;
         store_cnt_ff   <= store_cnt_in;
         store_start_ff <= store_start_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               carg_pkg::REG_WINDOW:    win_ff       <= csr_bus.data;
               carg_pkg::REG_SRC_LIMIT: src_lim_ff   <= csr_bus.data;
               carg_pkg::REG_NET_LIMIT: net_lim_ff   <= csr_bus.data;
               carg_pkg::REG_BAN_SEC:   ban_sec_ff   <= csr_bus.data;
               carg_pkg::REG_STORE_LIM: store_lim_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      free_ff        <= free_in;
      old_ff         <= old_in;
      best_ff        <= best_in;
      ban_slot_ff    <= ban_slot_in;
      cmd_ff         <= cmd_in;
      ip_ff          <= ip_in;
      now_ff         <= now_in;
      press_ff       <= press_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

`ifndef NO_ASSERTIONS
   a_rsp_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> state_ff == S_RESP) else $error("response outside resp state");
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> !rsp_vld_ff)
      else $error("request taken while response pending");
   a_acc_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_acc_ff == (rsp_verdict_ff == carg_pkg::V_OK)))
      else $error("accepted flag disagrees with verdict");
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && idx_ff == carg_pkg::IDX_W'(carg_pkg::MAX_ENTRIES - 1))
      |=> state_ff == S_IDLE) else $error("clearing pass did not finish");
   a_store_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BAN || state_ff == S_SRC || state_ff == S_NET)
      |-> cmd_ff != carg_pkg::CMD_STORE) else $error("store word in table scan");
`endif

endmodule
